FILE: sv/hdpi_pkg.sv
// Shared types, constants and the arctangent table for the dead-reckoning
// position integrator. No dependencies.
package hdpi_pkg;

    localparam int TURN_W = 18;
    localparam int DIST_W = 20;
    localparam int HEAD_W = 17;
    localparam int SUM_W = 19;
    localparam int ANG_W = 26;
    localparam int VEC_W = 35;
    localparam int PROD_W = VEC_W + DIST_W;
    localparam int TERM_W = PROD_W - 30;
    localparam int OUT_W = 32;

    localparam logic signed [SUM_W-1:0] FULL_TURN = 19'sd92160;
    localparam logic [HEAD_W-1:0] DEG90 = 17'd23040;
    localparam logic [HEAD_W-1:0] DEG270 = 17'd69120;
    localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 35'sd652032875;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd536870912);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_CORDIC,
        ST_MULT,
        ST_ACCUM,
        ST_EMIT
    } hdpi_state_t;

    // atan(2^-i) in degrees Q.16, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
        logic signed [ANG_W-1:0] v;
        v = '0;
        unique case (idx)
            0: v = 26'sd2949120;
            1: v = 26'sd1740967;
            2: v = 26'sd919879;
            3: v = 26'sd466945;
            4: v = 26'sd234379;
            5: v = 26'sd117304;
            6: v = 26'sd58666;
            7: v = 26'sd29335;
            8: v = 26'sd14668;
            9: v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/hdpi_in_if.sv
// Input channel: one move (turn, distance, end mark) per beat.
// Depends on hdpi_pkg.
interface hdpi_in_if
    import hdpi_pkg::*;
();
    logic valid;
    logic ready;
    logic signed [TURN_W-1:0] turn;
    logic [DIST_W-1:0] distance;
    logic end_of_path;

    modport source (output valid, output turn, output distance, output end_of_path,
                    input ready);
    modport sink (input valid, input turn, input distance, input end_of_path,
                  output ready);
endinterface

FILE: sv/hdpi_out_if.sv
// Output channel: final position and saturation flag per beat.
// Depends on hdpi_pkg.
interface hdpi_out_if
    import hdpi_pkg::*;
();
    logic valid;
    logic ready;
    logic signed [OUT_W-1:0] x_position;
    logic signed [OUT_W-1:0] y_position;
    logic saturated;

    modport source (output valid, output x_position, output y_position,
                    output saturated, input ready);
    modport sink (input valid, input x_position, input y_position,
                  input saturated, output ready);
endinterface

FILE: sv/heading_distance_position_integrator.sv
// Dead-reckoning position integrator: heading wrap, CORDIC sine/cosine,
// bit-serial distance multiply, saturating accumulate.
// Depends on hdpi_pkg, hdpi_in_if, hdpi_out_if.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------
//  in_ch    | in  | turn, distance, end_of_path
//  out_ch   | out | x_position, y_position, saturated
//
// One move runs the heading wrap loop, one CORDIC rotation per cycle, then
// one distance bit per cycle in the shift-add multiplier, then the
// accumulate step. An end-of-path move adds an emit step that loads the
// output register. Reset clears heading, position and flag. A result waits
// in the output register while the next move runs; a second result stalls
// only if the first was not yet taken.
module heading_distance_position_integrator
    import hdpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int POSITION_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    hdpi_in_if.sink in_ch,
    hdpi_out_if.source out_ch
);

    localparam int PW = POSITION_WIDTH;
    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);
    localparam int MCW = 5;
    localparam logic [MCW-1:0] LAST_BIT = MCW'(DIST_W - 1);
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] PMAX = {3'b000, {(PW-1){1'b1}}};
    localparam logic signed [SW-1:0] PMIN = {3'b111, {(PW-1){1'b0}}};
    localparam int EW = (PW > OUT_W) ? PW : OUT_W;
    localparam logic signed [EW-1:0] OMAX = {{(EW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [EW-1:0] OMIN = {{(EW-31){1'b1}}, {31{1'b0}}};

    hdpi_state_t state_reg, state_next;

    logic [HEAD_W-1:0] heading_reg;
    logic signed [PW-1:0] xacc_reg, yacc_reg;
    logic sat_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [DIST_W-1:0] dist_reg;
    logic last_reg;
    logic neg_reg;
    logic signed [ANG_W-1:0] ang_reg;
    logic signed [VEC_W-1:0] cx_reg, cy_reg;
    logic [CW-1:0] step_reg;
    logic [MCW-1:0] bit_reg;
    logic signed [PROD_W-1:0] mx_reg, my_reg, px_reg, py_reg;
    logic out_valid_reg;
    logic signed [OUT_W-1:0] xout_reg, yout_reg;
    logic sat_out_reg;

    // wrap status
    logic wrap_low, wrap_high;
    assign wrap_low = sum_reg < 0;
    assign wrap_high = sum_reg >= FULL_TURN;

    // quadrant fold of the wrapped heading
    logic [HEAD_W-1:0] head_w;
    logic signed [ANG_W-1:0] ang_fold;
    logic fold_neg;
    assign head_w = sum_reg[HEAD_W-1:0];
    always_comb
    begin
        fold_neg = 1'b0;
        priority if (head_w > DEG90 && head_w < DEG270)
        begin
            ang_fold = (ANG_W'(signed'({1'b0, head_w})) - ANG_W'(46080)) <<< 8;
            fold_neg = 1'b1;
        end
        else if (head_w >= DEG270)
            ang_fold = (ANG_W'(signed'({1'b0, head_w})) - ANG_W'(92160)) <<< 8;
        else
            ang_fold = ANG_W'(signed'({1'b0, head_w})) <<< 8;
    end

    // CORDIC rotation step
    logic signed [VEC_W-1:0] dx, dy;
    logic signed [ANG_W-1:0] atan_i;
    logic signed [VEC_W-1:0] cx_rot, cy_rot;
    logic signed [ANG_W-1:0] ang_rot;
    assign dx = cy_reg >>> step_reg;
    assign dy = cx_reg >>> step_reg;
    assign atan_i = atan_q16(int'(step_reg));
    always_comb
    begin
        if (ang_reg >= 0)
        begin
            cx_rot = cx_reg - dx;
            cy_rot = cy_reg + dy;
            ang_rot = ang_reg - atan_i;
        end
        else
        begin
            cx_rot = cx_reg + dx;
            cy_rot = cy_reg - dy;
            ang_rot = ang_reg + atan_i;
        end
    end

    // rounding and saturating accumulate
    logic signed [PROD_W-1:0] rx, ry;
    logic signed [TERM_W-1:0] tx, ty;
    logic signed [SW-1:0] sx, sy;
    logic hit_x, hit_y;
    logic signed [PW-1:0] xacc_sat, yacc_sat;
    assign rx = (px_reg + ROUND_HALF) >>> 30;
    assign ry = (py_reg + ROUND_HALF) >>> 30;
    assign tx = rx[TERM_W-1:0];
    assign ty = ry[TERM_W-1:0];
    assign sx = SW'(xacc_reg) + SW'(tx);
    assign sy = SW'(yacc_reg) + SW'(ty);
    always_comb
    begin
        hit_x = (sx > PMAX) || (sx < PMIN);
        hit_y = (sy > PMAX) || (sy < PMIN);
        xacc_sat = (sx > PMAX) ? PMAX[PW-1:0] : (sx < PMIN) ? PMIN[PW-1:0] : sx[PW-1:0];
        yacc_sat = (sy > PMAX) ? PMAX[PW-1:0] : (sy < PMIN) ? PMIN[PW-1:0] : sy[PW-1:0];
    end

    // output clamp to 32 bits
    logic signed [EW-1:0] ex, ey;
    logic oclip;
    logic signed [OUT_W-1:0] xclip, yclip;
    assign ex = EW'(xacc_reg);
    assign ey = EW'(yacc_reg);
    always_comb
    begin
        oclip = (ex > OMAX) || (ex < OMIN) || (ey > OMAX) || (ey < OMIN);
        xclip = (ex > OMAX) ? OMAX[OUT_W-1:0] : (ex < OMIN) ? OMIN[OUT_W-1:0] : ex[OUT_W-1:0];
        yclip = (ey > OMAX) ? OMAX[OUT_W-1:0] : (ey < OMIN) ? OMIN[OUT_W-1:0] : ey[OUT_W-1:0];
    end

    logic emit_go;
    assign emit_go = !out_valid_reg || out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_ch.valid) state_next = ST_WRAP;
            ST_WRAP:   if (!wrap_low && !wrap_high) state_next = ST_CORDIC;
            ST_CORDIC: if (step_reg == LAST_STEP) state_next = ST_MULT;
            ST_MULT:   if (bit_reg == LAST_BIT) state_next = ST_ACCUM;
            ST_ACCUM:  state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (emit_go) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        out_ch.valid = out_valid_reg;
        out_ch.x_position = xout_reg;
        out_ch.y_position = yout_reg;
        out_ch.saturated = sat_out_reg;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            heading_reg <= '0;
            xacc_reg <= '0;
            yacc_reg <= '0;
            sat_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_WRAP && !wrap_low && !wrap_high)
                heading_reg <= head_w;
            if (state_reg == ST_ACCUM)
            begin
                xacc_reg <= xacc_sat;
                yacc_reg <= yacc_sat;
                if (hit_x || hit_y)
                    sat_reg <= 1'b1;
            end
            if (state_reg == ST_EMIT && emit_go)
            begin
                out_valid_reg <= 1'b1;
                heading_reg <= '0;
                xacc_reg <= '0;
                yacc_reg <= '0;
                sat_reg <= 1'b0;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                sum_reg <= SUM_W'(signed'({2'b00, heading_reg})) + SUM_W'(in_ch.turn);
                dist_reg <= in_ch.distance;
                last_reg <= in_ch.end_of_path;
            end
            ST_WRAP:
            begin
                priority if (wrap_low)
                    sum_reg <= sum_reg + FULL_TURN;
                else if (wrap_high)
                    sum_reg <= sum_reg - FULL_TURN;
                else
                begin
                    ang_reg <= ang_fold;
                    neg_reg <= fold_neg;
                    cx_reg <= CORDIC_GAIN;
                    cy_reg <= '0;
                    step_reg <= '0;
                end
            end
            ST_CORDIC:
            begin
                cx_reg <= cx_rot;
                cy_reg <= cy_rot;
                ang_reg <= ang_rot;
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    // x term uses -sin, y term uses cos (after the final rotation)
                    mx_reg <= PROD_W'(neg_reg ? cy_rot : -cy_rot);
                    my_reg <= PROD_W'(neg_reg ? -cx_rot : cx_rot);
                    px_reg <= '0;
                    py_reg <= '0;
                    bit_reg <= '0;
                end
            end
            ST_MULT:
            begin
                if (dist_reg[0])
                begin
                    px_reg <= px_reg + mx_reg;
                    py_reg <= py_reg + my_reg;
                end
                mx_reg <= mx_reg <<< 1;
                my_reg <= my_reg <<< 1;
                dist_reg <= dist_reg >> 1;
                bit_reg <= bit_reg + 1'b1;
            end
            ST_ACCUM:
            begin
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    xout_reg <= xclip;
                    yout_reg <= yclip;
                    sat_out_reg <= sat_reg || oclip;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
